/* sv/epm_pkg.sv */
// ----------------------------------------------------------------------------
// epm_pkg: shared types and constants of the euler pose matrix core
// cordic arctangent table, gain and the sine/cosine bundle between blocks
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int CordicSteps = 30;
  localparam int TrigBits    = 32;   // q30 sine/cosine, signed
  localparam int CordicBits  = 34;   // cordic working width

  localparam logic [31:0] CordicGain = 32'd652032874;

  // atan(2^-i) in 2^32 per turn
  localparam logic [31:0] AtanTurn32 [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic signed [TrigBits-1:0] c;
    logic signed [TrigBits-1:0] s;
  } sincos_t;

endpackage

/* sv/epm_cordic.sv */
// ----------------------------------------------------------------------------
// epm_cordic: pipelined sine/cosine lane
// one cordic iteration per stage, quadrant fold in a final stage
// ----------------------------------------------------------------------------
module epm_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output epm_pkg::sincos_t        trig_o
);
  import epm_pkg::*;

  logic signed [CordicBits-1:0] x_q [CordicSteps];
  logic signed [CordicBits-1:0] y_q [CordicSteps];
  logic signed [CordicBits-1:0] z_q [CordicSteps];
  logic [1:0]                   quad_q [CordicSteps];
  logic signed [CordicBits-1:0] z_init;
  sincos_t                      trig_d, trig_q;

  // remaining angle scaled to 2^32 per turn
  assign z_init = $signed(CordicBits'(angle_i[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [CordicBits-1:0] x_in, y_in, z_in, atan;
    logic [1:0]                   quad_in;
    if (i == 0) begin : g_first
      assign x_in    = $signed({2'b00, CordicGain});
      assign y_in    = '0;
      assign z_in    = z_init;
      assign quad_in = angle_i[ANGLE_BITS-1 -: 2];
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign quad_in = quad_q[i-1];
    end
    assign atan = $signed({2'b00, AtanTurn32[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[CordicBits-1]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - atan;
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + atan;
        end
        quad_q[i] <= quad_in;
      end
    end
  end

  always_comb begin
    case (quad_q[CordicSteps-1])
      2'd0: begin
        trig_d.c = x_q[CordicSteps-1][TrigBits-1:0];
        trig_d.s = y_q[CordicSteps-1][TrigBits-1:0];
      end
      2'd1: begin
        trig_d.c = -y_q[CordicSteps-1][TrigBits-1:0];
        trig_d.s = x_q[CordicSteps-1][TrigBits-1:0];
      end
      2'd2: begin
        trig_d.c = -x_q[CordicSteps-1][TrigBits-1:0];
        trig_d.s = -y_q[CordicSteps-1][TrigBits-1:0];
      end
      default: begin
        trig_d.c = y_q[CordicSteps-1][TrigBits-1:0];
        trig_d.s = -x_q[CordicSteps-1][TrigBits-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

/* sv/epm_merge.sv */
// ----------------------------------------------------------------------------
// epm_merge: combines the three lanes into the rotation entries
// products, second products and sums, then round and saturate
// ----------------------------------------------------------------------------
module epm_merge #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  epm_pkg::sincos_t                        roll_i,
  input  epm_pkg::sincos_t                        pitch_i,
  input  epm_pkg::sincos_t                        yaw_i,
  output logic signed [8:0][COEF_FRAC_BITS+1:0]   elem_o
);
  import epm_pkg::*;

  localparam int CoefBits = COEF_FRAC_BITS + 2;
  localparam int Sh       = 30 - COEF_FRAC_BITS;
  localparam logic signed [34:0] Rnd =
      (Sh > 0) ? (35'sd1 <<< ((Sh > 0) ? Sh - 1 : 0)) : 35'sd0;
  localparam logic signed [34:0] One = 35'sd1 <<< COEF_FRAC_BITS;

  function automatic logic signed [TrigBits-1:0] qmul(
    input logic signed [TrigBits-1:0] a,
    input logic signed [TrigBits-1:0] b
  );
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic signed [CoefBits-1:0] to_coef(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = (35'(v) + Rnd) >>> Sh;
    if (r > One) r = One;
    if (r < -One) r = -One;
    return r[CoefBits-1:0];
  endfunction

  // stage a: first products
  logic signed [TrigBits-1:0] p00_q, p01_q, p12_q, p22_q, rsp_q, rcp_q;
  logic signed [TrigBits-1:0] t10_q, t11_q, t20_q, t21_q, sp_q, cy_q, sy_q;
  // stage b: full-precision entries
  logic signed [33:0]         ent_q [9];
  logic signed [CoefBits-1:0] coef_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= qmul(pitch_i.c, yaw_i.c);
      p01_q <= qmul(pitch_i.c, yaw_i.s);
      p12_q <= qmul(roll_i.s, pitch_i.c);
      p22_q <= qmul(roll_i.c, pitch_i.c);
      rsp_q <= qmul(roll_i.s, -pitch_i.s);
      rcp_q <= qmul(roll_i.c, -pitch_i.s);
      t10_q <= qmul(roll_i.c, -yaw_i.s);
      t11_q <= qmul(roll_i.c, yaw_i.c);
      t20_q <= qmul(-roll_i.s, -yaw_i.s);
      t21_q <= qmul(-roll_i.s, yaw_i.c);
      sp_q  <= pitch_i.s;
      cy_q  <= yaw_i.c;
      sy_q  <= yaw_i.s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q[0] <= 34'(p00_q);
      ent_q[1] <= 34'(p01_q);
      ent_q[2] <= 34'(sp_q);
      ent_q[3] <= 34'(qmul(rsp_q, cy_q)) + 34'(t10_q);
      ent_q[4] <= 34'(qmul(rsp_q, sy_q)) + 34'(t11_q);
      ent_q[5] <= 34'(p12_q);
      ent_q[6] <= 34'(qmul(rcp_q, cy_q)) + 34'(t20_q);
      ent_q[7] <= 34'(qmul(rcp_q, sy_q)) + 34'(t21_q);
      ent_q[8] <= 34'(p22_q);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_coef
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        coef_q[k] <= to_coef(ent_q[k]);
      end
    end
    assign elem_o[k] = coef_q[k];
  end

endmodule

/* sv/euler_pose_matrix_core.sv */
// ----------------------------------------------------------------------------
// euler_pose_matrix_core: rotation entries and translation of a pose
// three cordic lanes feed a product/merge pipeline, output register plus skid
// ----------------------------------------------------------------------------
// a request passes the cordic stages, quadrant fold, merge stages and output register
// throughput: one request per cycle, set by the fully pipelined cordic lanes
// and the merge multipliers; a stalled output parks one result in the skid
// register, in_stall_o rises only once that register is full
// reset: clears the pipeline, output and skid valid bits; data is not reset
module euler_pose_matrix_core #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int POS_BITS       = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ANGLE_BITS-1:0]              roll_angle_i,
  input  logic [ANGLE_BITS-1:0]              pitch_angle_i,
  input  logic [ANGLE_BITS-1:0]              yaw_angle_i,
  input  logic signed [POS_BITS-1:0]         pos_x_i,
  input  logic signed [POS_BITS-1:0]         pos_y_i,
  input  logic signed [POS_BITS-1:0]         pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_0_0_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_0_1_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_0_2_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_1_0_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_1_1_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_1_2_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_2_0_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_2_1_o,
  output logic signed [COEF_FRAC_BITS+1:0]   elem_2_2_o,
  output logic signed [POS_BITS-1:0]         trans_x_o,
  output logic signed [POS_BITS-1:0]         trans_y_o,
  output logic signed [POS_BITS-1:0]         trans_z_o
);
  import epm_pkg::*;

  // cordic stages, quadrant fold, three merge stages
  localparam int PipeDepth = CordicSteps + 1 + 3;
  localparam int CoefBits  = COEF_FRAC_BITS + 2;

  typedef struct packed {
    logic signed [8:0][CoefBits-1:0] elem;
    logic signed [2:0][POS_BITS-1:0] trans;
  } result_t;

  logic                            en;
  logic [PipeDepth-1:0]            pv_q;
  logic signed [2:0][POS_BITS-1:0] pos_q [PipeDepth];
  sincos_t                         roll_trig, pitch_trig, yaw_trig;
  logic signed [8:0][CoefBits-1:0] merge_elem;
  result_t                         last_res, out_q, skid_q;
  logic                            out_v_q, skid_v_q, take;

  // the whole pipe advances unless the skid register holds a result
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  epm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i (clk_i), .en_i (en), .angle_i (roll_angle_i), .trig_o (roll_trig)
  );
  epm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i (clk_i), .en_i (en), .angle_i (pitch_angle_i), .trig_o (pitch_trig)
  );
  epm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i (clk_i), .en_i (en), .angle_i (yaw_angle_i), .trig_o (yaw_trig)
  );

  epm_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .roll_i  (roll_trig),
    .pitch_i (pitch_trig),
    .yaw_i   (yaw_trig),
    .elem_o  (merge_elem)
  );

  // request valid bits travel alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // translation delay line, matched to the lane latency
  for (genvar k = 0; k < PipeDepth; k++) begin : g_pos
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (k == 0) begin
          pos_q[k] <= {pos_z_i, pos_y_i, pos_x_i};
        end else begin
          pos_q[k] <= pos_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign last_res.elem  = merge_elem;
  assign last_res.trans = pos_q[PipeDepth-1];

  assign take = out_v_q && !out_stall_i;

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= pv_q[PipeDepth-1];
      end
    end else if (pv_q[PipeDepth-1] && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : last_res;
    end else if (en) begin
      skid_q <= last_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign elem_0_0_o  = out_q.elem[0];
  assign elem_0_1_o  = out_q.elem[1];
  assign elem_0_2_o  = out_q.elem[2];
  assign elem_1_0_o  = out_q.elem[3];
  assign elem_1_1_o  = out_q.elem[4];
  assign elem_1_2_o  = out_q.elem[5];
  assign elem_2_0_o  = out_q.elem[6];
  assign elem_2_1_o  = out_q.elem[7];
  assign elem_2_2_o  = out_q.elem[8];
  assign trans_x_o   = out_q.trans[0];
  assign trans_y_o   = out_q.trans[1];
  assign trans_z_o   = out_q.trans[2];

  // the skid entry is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without output");

  // a parked result is never dropped while the output stays stalled
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q && out_v_q) else $error("skid lost");

  // draining the skid refills the output in the next cycle
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && take |=> out_v_q && !skid_v_q) else $error("skid drain");

endmodule

/* sim/euler_pose_matrix_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_pose_matrix_core_tb: self-checking bench of the pose matrix core
// drives poses in bursts with gaps, stalls the result side on its own
// pattern, predicts rotation entries and translation with its own cordic model
// or a typed-in answer, and compares each result field by field in order
// ----------------------------------------------------------------------------
module euler_pose_matrix_core_tb;

  import epm_pkg::*;

  localparam int AngleW   = 16;
  localparam int FracW    = 14;
  localparam int PosW     = 24;
  localparam int CoefW    = FracW + 2;
  localparam int Latency  = 35;
  localparam int NumRand  = 1550;
  localparam int MaxCycles = 400000;
  localparam int HoldOff  = 300;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [PosW-1:0]  pos_t;

  typedef struct {
    logic [AngleW-1:0] roll, pitch, yaw;
    pos_t              px, py, pz;
  } pose_t;

  typedef struct {
    coef_t e [9];
    pos_t  tx, ty, tz;
  } matrix_t;

  // directed row: pose plus an optional typed-in answer
  typedef struct {
    pose_t   pose;
    bit      known;
    matrix_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [AngleW-1:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  pos_t pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  coef_t elem_0_0_o, elem_0_1_o, elem_0_2_o, elem_1_0_o, elem_1_1_o;
  coef_t elem_1_2_o, elem_2_0_o, elem_2_1_o, elem_2_2_o;
  pos_t trans_x_o, trans_y_o, trans_z_o;

  euler_pose_matrix_core #(
    .ANGLE_BITS(AngleW), .COEF_FRAC_BITS(FracW), .POS_BITS(PosW)
  ) u_top (.*);

  always #4 clk_i = ~clk_i;

  matrix_t pending_matrices[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      stim_done = 1'b0;
  bit      hold_req = 1'b0;   // sender asks receiver for a long hold-off
  bit      holding = 1'b0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // q30 sine and cosine of one binary angle
  function automatic void trig_q30(input logic [AngleW-1:0] ang,
                                   output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [1:0] quad;
    quad = ang[AngleW-1 -: 2];
    z = longint'(ang[AngleW-3:0]) <<< (32 - AngleW);
    x = CordicGain;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurn32[i];
      end else begin
        x += dx; y -= dy; z += AtanTurn32[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // round to the output grid and clamp to plus or minus one
  function automatic coef_t round_coef(longint v);
    longint r;
    longint one;
    one = 64'sd1 <<< FracW;
    r = (v + (64'sd1 <<< (30 - FracW - 1))) >>> (30 - FracW);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return coef_t'(r);
  endfunction

  function automatic matrix_t pose_matrix(pose_t p);
    matrix_t m;
    longint cr, sr, cp, sp, cy, sy, rsp, rcp;
    trig_q30(p.roll, cr, sr);
    trig_q30(p.pitch, cp, sp);
    trig_q30(p.yaw, cy, sy);
    rsp = mul_q30(sr, -sp);
    rcp = mul_q30(cr, -sp);
    m.e[0] = round_coef(mul_q30(cp, cy));
    m.e[1] = round_coef(mul_q30(cp, sy));
    m.e[2] = round_coef(sp);
    m.e[3] = round_coef(mul_q30(rsp, cy) + mul_q30(cr, -sy));
    m.e[4] = round_coef(mul_q30(rsp, sy) + mul_q30(cr, cy));
    m.e[5] = round_coef(mul_q30(sr, cp));
    m.e[6] = round_coef(mul_q30(rcp, cy) + mul_q30(-sr, -sy));
    m.e[7] = round_coef(mul_q30(rcp, sy) + mul_q30(-sr, cy));
    m.e[8] = round_coef(mul_q30(cr, cp));
    m.tx = p.px;
    m.ty = p.py;
    m.tz = p.pz;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got,
             want);
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and checker
  // --------------------------------------------------------------------------

  // receiver stall: phases of free run, random stall, and periodic pattern;
  // a long hold-off is counted here when the sender asks for it
  initial begin
    int mode;
    int len;
    forever begin
      @(negedge clk_i);
      if (hold_req && !holding) begin
        holding = 1'b1;
        out_stall_i <= 1'b1;
        for (int i = 0; i < HoldOff; i++) @(negedge clk_i);
        holding = 1'b0;
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(1, 40);
        for (int i = 0; i < len && !hold_req; i++) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 2) == 0);
            default: out_stall_i <= (i % 3 == 2);
          endcase
          @(negedge clk_i);
        end
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    matrix_t w;
    coef_t got [9];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_matrices.size() == 0) begin
        mismatch_count++;
        $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        w = pending_matrices.pop_front();
        got = '{elem_0_0_o, elem_0_1_o, elem_0_2_o, elem_1_0_o, elem_1_1_o,
                elem_1_2_o, elem_2_0_o, elem_2_1_o, elem_2_2_o};
        for (int i = 0; i < 9; i++)
          if (got[i] !== w.e[i])
            report_mismatch($sformatf("elem_%0d_%0d", i / 3, i % 3), got[i], w.e[i]);
        if (trans_x_o !== w.tx) report_mismatch("trans_x", trans_x_o, w.tx);
        if (trans_y_o !== w.ty) report_mismatch("trans_y", trans_y_o, w.ty);
        if (trans_z_o !== w.tz) report_mismatch("trans_z", trans_z_o, w.tz);
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // offer one pose and hold it until accepted; the prediction is queued at
  // the accepting edge so it can never trail its result
  task automatic send_pose(input pose_t p, input matrix_t want);
    in_valid_i    <= 1'b1;
    roll_angle_i  <= p.roll;
    pitch_angle_i <= p.pitch;
    yaw_angle_i   <= p.yaw;
    pos_x_i       <= p.px;
    pos_y_i       <= p.py;
    pos_z_i       <= p.pz;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_matrices.push_back(want);
    @(negedge clk_i);
  endtask

  function automatic pose_t rand_pose(int style);
    pose_t p;
    logic [AngleW-1:0] special [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                                        16'hffff, 16'h3fff, 16'h0001, 16'h7fff};
    if (style == 0) begin
      // near quadrant edges, where clamping and folding matter
      p.roll  = special[$urandom_range(0, 7)] + AngleW'($urandom_range(0, 6)) - AngleW'(3);
      p.pitch = special[$urandom_range(0, 7)] + AngleW'($urandom_range(0, 6)) - AngleW'(3);
      p.yaw   = special[$urandom_range(0, 7)] + AngleW'($urandom_range(0, 6)) - AngleW'(3);
    end else begin
      p.roll  = AngleW'($urandom);
      p.pitch = AngleW'($urandom);
      p.yaw   = AngleW'($urandom);
    end
    p.px = pos_t'($urandom);
    p.py = pos_t'($urandom);
    p.pz = pos_t'($urandom);
    return p;
  endfunction

  function automatic row_t mk_row(logic [AngleW-1:0] r, pi, y, pos_t x, yy, z);
    row_t t;
    t.pose = '{r, pi, y, x, yy, z};
    t.known = 1'b0;
    return t;
  endfunction

  row_t dir_rows[$];

  initial begin
    row_t t;
    matrix_t m;
    pose_t p;
    int burst;
    bit hold_sent;
    bit pause_done;
    hold_sent = 1'b0;
    pause_done = 1'b0;
    // identity pose: every entry is read straight off the formulas
    t = mk_row(16'h0000, 16'h0000, 16'h0000, 24'sh7fffff, -24'sh800000, 24'sh0);
    t.known = 1'b1;
    t.want.e = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                 16'sd0, 16'sd0, 16'sd16384};
    t.want.tx = 24'sh7fffff; t.want.ty = -24'sh800000; t.want.tz = 24'sh0;
    dir_rows.push_back(t);
    // quarter turn of pitch: sin pitch is one, cos pitch vanishes
    t = mk_row(16'h0000, 16'h4000, 16'h0000, -24'sd1, 24'sd1, 24'sh555555);
    t.known = 1'b1;
    t.want.e = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                 -16'sd16384, 16'sd0, 16'sd0};
    t.want.tx = -24'sd1; t.want.ty = 24'sd1; t.want.tz = 24'sh555555;
    dir_rows.push_back(t);
    dir_rows.push_back(mk_row(16'hffff, 16'hffff, 16'hffff, -24'sh800000, 24'sh7fffff,
                              -24'sh555556));
    dir_rows.push_back(mk_row(16'h4000, 16'h8000, 16'hc000, 24'sh2aaaaa, 0, -1));
    dir_rows.push_back(mk_row(16'h8000, 16'hc000, 16'h4000, 0, -1, 24'sh7fffff));
    dir_rows.push_back(mk_row(16'hc000, 16'h4000, 16'h8000, 24'sh123456, 24'sh654321, 0));
    dir_rows.push_back(mk_row(16'h3fff, 16'h7fff, 16'hbfff, 1, 2, 3));
    dir_rows.push_back(mk_row(16'h0001, 16'h4001, 16'h8001, -2, -3, -4));
    dir_rows.push_back(mk_row(16'h2000, 16'h2000, 16'h2000, 24'sh0f0f0f, 0, 0));
    dir_rows.push_back(mk_row(16'h5555, 16'haaaa, 16'h1234, 0, 24'sh0f0f0f, 0));
    dir_rows.push_back(mk_row(16'haaaa, 16'h5555, 16'hedcb, 0, 0, 24'sh0f0f0f));
    dir_rows.push_back(mk_row(16'hc001, 16'hffff, 16'h0000, -24'sh0f0f10, 5, 6));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      m = dir_rows[i].known ? dir_rows[i].want : pose_matrix(dir_rows[i].pose);
      send_pose(dir_rows[i].pose, m);
    end

    for (int n = 0; n < NumRand;) begin
      // long receiver hold-off while requests keep coming
      if (n >= 300 && !hold_sent) begin
        hold_sent = 1'b1;
        hold_req = 1'b1;
      end
      // sender pause until everything has drained
      if (n >= 800 && !pause_done) begin
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        while (pending_matrices.size() != 0) @(negedge clk_i);
      end
      burst = $urandom_range(1, 60);
      for (int k = 0; k < burst && n < NumRand; k++, n++) begin
        p = rand_pose($urandom_range(0, 3));
        send_pose(p, pose_matrix(p));
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // end of run and cycle limit
  // --------------------------------------------------------------------------
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (stim_done && pending_matrices.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("euler_pose_matrix_core verification clean");
    end else begin
      $display("euler_pose_matrix_core verification failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= MaxCycles);
    $display("timeout after %0d cycles", cycle_count);
    $display("euler_pose_matrix_core verification failed");
    $finish;
  end

endmodule
